/* src/spa_pkg.sv */
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the star polygon area block.
// ----------------------------------------------------------------------------
package spa_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_AREA_RD0,
        ST_AREA_RD,
        ST_AREA_MUL,
        ST_AREA_ACC,
        ST_DONE
    } spa_state_t;

    localparam int SUM_BITS  = 64;
    localparam int AREA_BITS = 58;
    localparam int CNT_BITS  = 7;

endpackage

/* src/spa_if.sv */
// ----------------------------------------------------------------------------
// spa_in_if / spa_out_if
// Valid/ready channels carrying vertex transfers and area results.
// ----------------------------------------------------------------------------
interface spa_in_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic                         last;

    modport source (output valid, point_x, point_y, center_x, center_y, last,
                    input ready);
    modport sink   (input valid, point_x, point_y, center_x, center_y, last,
                    output ready);
endinterface

interface spa_out_if;
    logic        valid;
    logic        ready;
    logic [57:0] twice_area;
    logic [6:0]  vertex_count;
    logic        overflow;

    modport source (output valid, twice_area, vertex_count, overflow,
                    input ready);
    modport sink   (input valid, twice_area, vertex_count, overflow,
                    output ready);
endinterface

/* src/spa_ram.sv */
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* src/star_polygon_area_top.sv */
// ----------------------------------------------------------------------------
// star_polygon_area_top
// Keeps cell vertices in polar-angle order in RAM and returns twice the
// shoelace area of the cell on its last vertex.
//
//  channel | dir | payload
//  in_ch   | in  | point_x, point_y, center_x, center_y, last
//  out_ch  | out | twice_area, vertex_count, overflow
//
// One vertex at a time. Insertion reads and compares stored entries in order
// until the new vertex sorts below one, shifts the entries from there up by
// one, top first, and writes the new vertex in the freed place. Last vertex
// adds an area pass over all stored entries.
// Reset clears state, count and the drop and valid flags only; RAM contents need no clear.
// The result sits in an output register; new vertices are taken while it
// waits, and only the next cell's result stalls until it has been transferred.
// ----------------------------------------------------------------------------
module star_polygon_area_top
    import spa_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    spa_in_if.sink    in_ch,
    spa_out_if.source out_ch
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int KW = $clog2(MAX_POINTS + 1);
    localparam int RW = COORD_BITS + 1;
    localparam int PW = 2 * RW;
    localparam int DW = 2 * RW;

    spa_state_t state_reg, state_next;

    logic [KW-1:0] kept_reg, kept_next;
    logic          drop_reg, drop_next;
    logic [KW-1:0] idx_reg, idx_next;
    logic [KW-1:0] pos_reg, pos_next;
    logic signed [RW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic          last_reg, last_next;
    logic signed [RW-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [RW-1:0] xp_reg, xp_next, yp_reg, yp_next;
    logic signed [PW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic          ov_reg, ov_next;
    logic [AREA_BITS-1:0] area_reg, area_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;

    // RAM port signals
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;
    logic signed [RW-1:0] mx, my;

    spa_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_vert_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mx = rd_data[DW-1:RW];
    assign my = rd_data[RW-1:0];

    // Exact angle compare: new vector below stored one
    logic signed [RW-1:0] ax, bx;
    logic ha, hb, new_less;
    logic signed [PW-1:0] cr1, cr2;
    always_comb
    begin
        ax = (rx_reg == '0 && ry_reg == '0) ? RW'(1) : rx_reg;
        bx = (mx == '0 && my == '0) ? RW'(1) : mx;
        ha = (ry_reg < 0) || (ry_reg == '0 && ax < 0);
        hb = (my < 0) || (my == '0 && bx < 0);
        cr1 = PW'(ax) * PW'(my);
        cr2 = PW'(ry_reg) * PW'(bx);
        if (ha != hb)
            new_less = ha < hb;
        else
            new_less = cr1 > cr2;
    end

    // Saturating accumulate and magnitude
    localparam logic signed [SUM_BITS-1:0] LIM = SUM_BITS'(64'sd1 <<< 62);
    logic signed [SUM_BITS-1:0] term, acc;
    logic [SUM_BITS-1:0] mag;
    always_comb
    begin
        term = SUM_BITS'(pa_reg) - SUM_BITS'(pb_reg);
        acc  = sum_reg + term;
        if (acc > LIM)
            acc = LIM;
        else if (acc < -LIM)
            acc = -LIM;
        mag = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    end

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kept_reg  <= '0;
            drop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kept_reg  <= kept_next;
            drop_reg  <= drop_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        last_reg <= last_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        xp_reg   <= xp_next;
        yp_reg   <= yp_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        sum_reg  <= sum_next;
        area_reg <= area_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = ov_reg;
    assign out_ch.twice_area   = area_reg;
    assign out_ch.vertex_count = cnt_reg;
    assign out_ch.overflow     = ovf_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        kept_next = kept_reg;
        drop_next = drop_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        last_next = last_reg;
        x0_next = x0_reg;
        y0_next = y0_reg;
        xp_next = xp_reg;
        yp_next = yp_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        sum_next = sum_reg;
        ov_next = ov_reg;
        area_next = area_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = {rx_reg, ry_reg};
        rd_addr = idx_reg[AW-1:0];

        if (ov_reg && out_ch.ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    rx_next = RW'(in_ch.point_x) - RW'(in_ch.center_x);
                    ry_next = RW'(in_ch.point_y) - RW'(in_ch.center_y);
                    last_next = in_ch.last;
                    idx_next = '0;
                    pos_next = kept_reg;
                    if (kept_reg >= KW'(MAX_POINTS))
                    begin
                        drop_next = 1'b1;
                        state_next = in_ch.last ? ST_AREA_RD0 : ST_IDLE;
                    end
                    else if (kept_reg == '0)
                        state_next = ST_PLACE;
                    else
                        state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
                state_next = ST_SRCH_CMP;
            ST_SRCH_CMP:
            begin
                if (new_less)
                begin
                    pos_next = idx_reg;
                    idx_next = kept_reg - KW'(1);
                    state_next = ST_SHIFT_RD;
                end
                else if (idx_reg + KW'(1) == kept_reg)
                    state_next = ST_PLACE;
                else
                begin
                    idx_next = idx_reg + KW'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            // Move entries pos..kept-1 up by one, top first
            ST_SHIFT_RD:
                state_next = ST_SHIFT_WR;
            ST_SHIFT_WR:
            begin
                wr_en = 1'b1;
                wr_addr = AW'(idx_reg + KW'(1));
                wr_data = rd_data;
                if (idx_reg == pos_reg)
                    state_next = ST_PLACE;
                else
                begin
                    idx_next = idx_reg - KW'(1);
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_PLACE:
            begin
                wr_en = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                kept_next = kept_reg + KW'(1);
                idx_next = '0;
                state_next = last_reg ? ST_AREA_RD0 : ST_IDLE;
            end
            // Area pass: fetch entry 0, then walk edges
            ST_AREA_RD0:
            begin
                rd_addr = '0;
                sum_next = '0;
                idx_next = '0;
                state_next = (kept_reg == '0) ? ST_DONE : ST_AREA_RD;
            end
            ST_AREA_RD:
            begin
                if (idx_reg == '0)
                begin
                    x0_next = mx;
                    y0_next = my;
                end
                xp_next = mx;
                yp_next = my;
                rd_addr = AW'(idx_reg + KW'(1));
                state_next = ST_AREA_MUL;
            end
            ST_AREA_MUL:
            begin
                if (idx_reg + KW'(1) == kept_reg)
                begin
                    pa_next = PW'(xp_reg) * PW'(y0_reg);
                    pb_next = PW'(x0_reg) * PW'(yp_reg);
                end
                else
                begin
                    pa_next = PW'(xp_reg) * PW'(my);
                    pb_next = PW'(mx) * PW'(yp_reg);
                end
                state_next = ST_AREA_ACC;
            end
            ST_AREA_ACC:
            begin
                sum_next = acc;
                rd_addr = AW'(idx_reg + KW'(1));
                if (idx_reg + KW'(1) == kept_reg)
                    state_next = ST_DONE;
                else
                begin
                    idx_next = idx_reg + KW'(1);
                    state_next = ST_AREA_RD;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg)
                begin
                    area_next = (mag > SUM_BITS'({AREA_BITS{1'b1}})) ?
                                {AREA_BITS{1'b1}} : mag[AREA_BITS-1:0];
                    cnt_next = CNT_BITS'(kept_reg);
                    ovf_next = drop_reg;
                    ov_next = 1'b1;
                    kept_next = '0;
                    drop_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
